/* rtl/event_rate_meter_unit_defines.svh */
// Assertion macros shared by the event rate meter checker
`ifndef EVENT_RATE_METER_UNIT_DEFINES_SVH
`define EVENT_RATE_METER_UNIT_DEFINES_SVH

// consequent in the cycle after the antecedent
`define ERM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// delayed consequent after the antecedent
`define ERM_ASSERT_AFTER3(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##3 (cons)) \
    else $error(msg);

`endif

/* rtl/erm_pkg.sv */
// Types, constants and control store of the event rate meter
`timescale 1ns / 1ps

package erm_pkg;

  // field widths
  localparam int OP_W     = 2;
  localparam int INC_W    = 16;
  localparam int TIME_W   = 32;
  localparam int CNT_W    = 32;
  localparam int RATE_W   = 40;
  localparam int FRAC_W   = 8;
  localparam int PROD_W   = CNT_W + TIME_W;
  localparam int QUO_W    = PROD_W + FRAC_W - TIME_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int DCNT_W   = $clog2(DIV_STEPS);
  localparam int PC_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 32;

  // stream widths
  localparam int IN_TDATA_W  = INC_W + TIME_W;
  localparam int IN_TUSER_W  = OP_W;
  localparam int OUT_TDATA_W = 2 * RATE_W + CNT_W;
  localparam int OUT_TUSER_W = 1;

  // rate constants, UQ32.8
  localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(1 << FRAC_W);
  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  // register reset values
  localparam logic [CFG_W-1:0] INTERVAL_RESET = 32'd1000;
  localparam logic [CFG_W-1:0] TPS_RESET      = 32'd1000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_COUNT   = 2'd0,
    OP_START   = 2'd1,
    OP_STOPPED = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_t;

  // datapath operation of one control word
  typedef enum logic [3:0] {
    UOP_FETCH      = 4'd0,
    UOP_DISPATCH   = 4'd1,
    UOP_MUL_RATE   = 4'd2,
    UOP_DIV_LOAD   = 4'd3,
    UOP_DIV_STEP   = 4'd4,
    UOP_STORE_RATE = 4'd5,
    UOP_MUL_MEAN   = 4'd6,
    UOP_STORE_MEAN = 4'd7,
    UOP_EMIT       = 4'd8
  } uop_t;

  // jump condition: when true go to taken, else to plain
  typedef enum logic [2:0] {
    JC_NEVER     = 3'd0,
    JC_NO_INPUT  = 3'd1,
    JC_NO_UPDATE = 3'd2,
    JC_DIV_BUSY  = 3'd3,
    JC_OUT_FULL  = 3'd4
  } cond_t;

  typedef struct packed {
    uop_t            uop;
    cond_t           cond;
    logic [PC_W-1:0] taken;
    logic [PC_W-1:0] plain;
  } uword_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  // program addresses
  localparam logic [PC_W-1:0] PC_FETCH      = 4'd0;
  localparam logic [PC_W-1:0] PC_DISPATCH   = 4'd1;
  localparam logic [PC_W-1:0] PC_MUL_RATE   = 4'd2;
  localparam logic [PC_W-1:0] PC_LOAD_RATE  = 4'd3;
  localparam logic [PC_W-1:0] PC_STEP_RATE  = 4'd4;
  localparam logic [PC_W-1:0] PC_STORE_RATE = 4'd5;
  localparam logic [PC_W-1:0] PC_MUL_MEAN   = 4'd6;
  localparam logic [PC_W-1:0] PC_LOAD_MEAN  = 4'd7;
  localparam logic [PC_W-1:0] PC_STEP_MEAN  = 4'd8;
  localparam logic [PC_W-1:0] PC_STORE_MEAN = 4'd9;
  localparam logic [PC_W-1:0] PC_EMIT       = 4'd10;

  // control store
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      PC_FETCH:      w = '{UOP_FETCH,      JC_NO_INPUT,  PC_FETCH,     PC_DISPATCH};
      PC_DISPATCH:   w = '{UOP_DISPATCH,   JC_NO_UPDATE, PC_EMIT,      PC_MUL_RATE};
      PC_MUL_RATE:   w = '{UOP_MUL_RATE,   JC_NEVER,     PC_FETCH,     PC_LOAD_RATE};
      PC_LOAD_RATE:  w = '{UOP_DIV_LOAD,   JC_NEVER,     PC_FETCH,     PC_STEP_RATE};
      PC_STEP_RATE:  w = '{UOP_DIV_STEP,   JC_DIV_BUSY,  PC_STEP_RATE, PC_STORE_RATE};
      PC_STORE_RATE: w = '{UOP_STORE_RATE, JC_NEVER,     PC_FETCH,     PC_MUL_MEAN};
      PC_MUL_MEAN:   w = '{UOP_MUL_MEAN,   JC_NEVER,     PC_FETCH,     PC_LOAD_MEAN};
      PC_LOAD_MEAN:  w = '{UOP_DIV_LOAD,   JC_NEVER,     PC_FETCH,     PC_STEP_MEAN};
      PC_STEP_MEAN:  w = '{UOP_DIV_STEP,   JC_DIV_BUSY,  PC_STEP_MEAN, PC_STORE_MEAN};
      PC_STORE_MEAN: w = '{UOP_STORE_MEAN, JC_NEVER,     PC_FETCH,     PC_EMIT};
      PC_EMIT:       w = '{UOP_EMIT,       JC_OUT_FULL,  PC_EMIT,      PC_FETCH};
      default:       w = '{UOP_FETCH,      JC_NEVER,     PC_FETCH,     PC_FETCH};
    endcase
    return w;
  endfunction

endpackage

/* rtl/erm_divider.sv */
// Restoring divider: floor(product * 256 / divisor), one quotient bit per cycle while step is set
`timescale 1ns / 1ps

module erm_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  erm_pkg::div_ctrl_t            ctrl,
  input  logic [erm_pkg::PROD_W-1:0]    product,
  input  logic [erm_pkg::TIME_W-1:0]    divisor,
  output logic [erm_pkg::QUO_W-1:0]     quotient,
  output logic                          overflow,
  output logic                          last
);
  import erm_pkg::*;

  logic [TIME_W-1:0] rem;
  logic [QUO_W-1:0]  low;
  logic [DCNT_W-1:0] cnt;
  logic              ovf;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;
  logic              fits;

  // trial subtract of the next dividend bit
  assign trial = {rem, low[QUO_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  assign quotient = low;
  assign overflow = ovf;
  assign last     = cnt == DCNT_W'(DIV_STEPS - 1);

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load) begin
      cnt <= '0;
    end else if (ctrl.step) begin
      cnt <= cnt + 1'b1;
    end
  end

  // partial remainder and quotient shifter; top dividend bits seed the remainder
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= product[PROD_W-1 -: TIME_W];
      low <= {product[PROD_W-TIME_W-1:0], {FRAC_W{1'b0}}};
      ovf <= product[PROD_W-1 -: TIME_W] >= divisor;
    end else if (ctrl.step) begin
      rem <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      low <= {low[QUO_W-2:0], fits};
    end
  end

endmodule

/* rtl/event_rate_meter_unit.sv */
// Event rate meter: top level with control store sequencer and datapath
// Items are handled one at a time. Start, stop, clear and count items that do
// not reach the update point pass through fetch, dispatch and emit. A count
// item that reaches the update point also runs two passes of the shared
// one-bit-per-cycle 40-bit divider (current rate, then average) before emit.
// Synchronous active-high rst clears the meter state and the output valid and sets
// both registers to 1000; no clearing pass is needed. A result waiting in the
// output register does not hold up the next input transaction.
`timescale 1ns / 1ps

module event_rate_meter_unit (
  input  logic                               clk,
  input  logic                               rst,
  // config write port
  input  logic                               cfg_we,
  input  logic [erm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [erm_pkg::CFG_W-1:0]          cfg_data,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [erm_pkg::IN_TDATA_W-1:0]     s_tdata,  // increment, time_now
  input  logic [erm_pkg::IN_TUSER_W-1:0]     s_tuser,  // opcode
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [erm_pkg::OUT_TDATA_W-1:0]    m_tdata,  // rate, average_rate, event_total
  output logic [erm_pkg::OUT_TUSER_W-1:0]    m_tuser   // recomputed
);
  import erm_pkg::*;

  // sequencer
  logic [PC_W-1:0]   pc;
  uword_t            uw;
  logic              take;

  // registers
  logic [CFG_W-1:0]  update_interval;
  logic [CFG_W-1:0]  ticks_per_second;

  // latched input transaction
  opcode_t           in_op;
  logic [INC_W-1:0]  in_inc;
  logic [TIME_W-1:0] in_now;

  // architectural state
  logic [CNT_W-1:0]  total_count;
  logic [CNT_W-1:0]  count_at_update;
  logic [TIME_W-1:0] time_at_update;
  logic [RATE_W-1:0] current_rate;
  logic [RATE_W-1:0] mean_rate;

  // working registers
  logic              passed;
  logic              zero_dcount;
  logic [TIME_W-1:0] dt;
  logic [PROD_W-1:0] product;
  logic [TIME_W-1:0] divisor;

  // output register
  logic [RATE_W-1:0] out_rate;
  logic [RATE_W-1:0] out_avg;
  logic [CNT_W-1:0]  out_total;
  logic              out_recomputed;

  // datapath nets
  logic              update_hit;
  logic [TIME_W-1:0] dt_now;
  logic [CNT_W-1:0]  dcount;
  logic [CNT_W-1:0]  mul_a;
  logic [PROD_W-1:0] mul_prod;
  logic              out_full;
  div_ctrl_t         div_ctrl;
  logic [QUO_W-1:0]  quotient;
  logic              div_ovf;
  logic              div_last;
  logic [RATE_W-1:0] div_result;

  assign uw       = ucode(pc);
  assign s_tready = uw.uop == UOP_FETCH;
  assign out_full = m_tvalid & ~m_tready;

  // update point: time must not run backwards and must exceed the interval
  assign dt_now     = in_now - time_at_update;
  assign update_hit = (in_op == OP_COUNT) && (in_now >= time_at_update) &&
                      (dt_now > update_interval);

  assign dcount   = total_count - count_at_update;
  assign mul_a    = (uw.uop == UOP_MUL_RATE) ? dcount : total_count;
  assign mul_prod = mul_a * ticks_per_second;

  assign div_ctrl.load = uw.uop == UOP_DIV_LOAD;
  assign div_ctrl.step = uw.uop == UOP_DIV_STEP;
  assign div_result    = div_ovf ? RATE_MAX : quotient;

  erm_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .product  (product),
    .divisor  (divisor),
    .quotient (quotient),
    .overflow (div_ovf),
    .last     (div_last)
  );

  // evaluate jump condition
  always_comb begin
    unique case (uw.cond)
      JC_NEVER:     take = 1'b0;
      JC_NO_INPUT:  take = ~s_tvalid;
      JC_NO_UPDATE: take = ~update_hit;
      JC_DIV_BUSY:  take = ~div_last;
      JC_OUT_FULL:  take = out_full;
      default:      take = 1'b0;
    endcase
  end

  // advance program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_FETCH;
    end else begin
      pc <= take ? uw.taken : uw.plain;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      update_interval  <= INTERVAL_RESET;
      ticks_per_second <= TPS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UPDATE_INTERVAL:  update_interval  <= cfg_data;
        REG_TICKS_PER_SECOND: ticks_per_second <= cfg_data;
      endcase
    end
  end

  // latch input transaction
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op  <= opcode_t'(s_tuser[OP_W-1:0]);
      in_inc <= s_tdata[INC_W-1:0];
      in_now <= s_tdata[INC_W +: TIME_W];
    end
  end

  // meter state, updated by the control word
  always_ff @(posedge clk) begin
    if (rst) begin
      total_count     <= '0;
      count_at_update <= '0;
      time_at_update  <= '0;
      current_rate    <= '0;
      mean_rate       <= '0;
      passed          <= 1'b0;
    end else begin
      case (uw.uop)
        UOP_DISPATCH: begin
          passed <= update_hit;
          unique case (in_op)
            OP_COUNT:   total_count  <= total_count + CNT_W'(in_inc);
            OP_START:   current_rate <= RATE_ONE;
            OP_STOPPED: current_rate <= '0;
            OP_CLEAR: begin
              total_count     <= '0;
              count_at_update <= '0;
              time_at_update  <= '0;
              current_rate    <= '0;
              mean_rate       <= '0;
            end
            default: ;
          endcase
        end
        UOP_STORE_RATE: current_rate <= zero_dcount ? '0 : div_result;
        UOP_STORE_MEAN: begin
          mean_rate       <= div_result;
          time_at_update  <= in_now;
          count_at_update <= total_count;
        end
        default: ;
      endcase
    end
  end

  // multiplier and divisor operands
  always_ff @(posedge clk) begin
    if (uw.uop == UOP_DISPATCH) begin
      dt <= dt_now;
    end
    if (uw.uop == UOP_MUL_RATE) begin
      product     <= mul_prod;
      divisor     <= dt;
      zero_dcount <= dcount == '0;
    end else if (uw.uop == UOP_MUL_MEAN) begin
      product <= mul_prod;
      divisor <= in_now;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (uw.uop == UOP_EMIT && !out_full) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.uop == UOP_EMIT && !out_full) begin
      out_rate       <= current_rate;
      out_avg        <= mean_rate;
      out_total      <= total_count;
      out_recomputed <= passed;
    end
  end

  assign m_tdata = {out_total, out_avg, out_rate};
  assign m_tuser = out_recomputed;

endmodule

/* rtl/erm_checker.sv */
// Port-level checker for the event rate meter, bound to the top level
`timescale 1ns / 1ps
`include "event_rate_meter_unit_defines.svh"

module erm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [erm_pkg::IN_TUSER_W-1:0]  s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [erm_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [erm_pkg::OUT_TUSER_W-1:0] m_tuser
);
  import erm_pkg::*;

  logic                                      in_txn;
  logic                                      stalled;
  logic [OUT_TUSER_W+OUT_TDATA_W-1:0]        res_bits;
  logic                                      clear_in;
  logic                                      start_in;
  logic                                      stop_in;
  logic                                      rate_one;
  logic                                      rate_zero;

  assign in_txn    = s_tvalid && s_tready && !m_tvalid;
  assign stalled   = m_tvalid && !m_tready;
  assign res_bits  = {m_tuser, m_tdata};
  assign clear_in  = in_txn && s_tuser == OP_CLEAR;
  assign start_in  = in_txn && s_tuser == OP_START;
  assign stop_in   = in_txn && s_tuser == OP_STOPPED;
  assign rate_one  = (m_tdata[RATE_W-1:0] == RATE_ONE) && !m_tuser[0];
  assign rate_zero = (m_tdata[RATE_W-1:0] == '0) && !m_tuser[0];

  // stalled result holds
  `ERM_ASSERT_NEXT(a_result_held, stalled, m_tvalid && $stable(res_bits), "stalled result changed")

  // one item in flight at a time
  `ERM_ASSERT_NEXT(a_single_item, s_tvalid && s_tready, !s_tready, "second item taken in flight")

  // clear item returns an all-zero result
  `ERM_ASSERT_AFTER3(a_clear_result, clear_in, m_tvalid && res_bits == '0, "clear result not zero")

  // start item forces the rate to one
  `ERM_ASSERT_AFTER3(a_start_result, start_in, m_tvalid && rate_one, "start item rate not one")

  // stopped item forces the rate to zero
  `ERM_ASSERT_AFTER3(a_stop_result, stop_in, m_tvalid && rate_zero, "stopped item rate not zero")

endmodule

bind event_rate_meter_unit erm_checker u_erm_checker (.*);

/* tb/tb_event_rate_meter_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the event rate meter: stream driver, monitor and rate predictor

module tb_event_rate_meter_unit;
  import erm_pkg::*;

  localparam int QUIET_LIMIT = 4000;  // cycles with no transaction on either side
  localparam int TAIL_CYCLES = 120;   // one full recompute plus margin
  localparam int MAX_REPORTS = 10;

  typedef enum logic [1:0] {
    JOB_ITEM  = 2'd0,
    JOB_CFG   = 2'd1,
    JOB_DRAIN = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t             kind;
    opcode_t               op;
    logic [INC_W-1:0]      inc;
    logic [TIME_W-1:0]     now;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      val;
  } job_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [RATE_W-1:0] avg;
    logic [CNT_W-1:0]  total;
    logic              recomp;
  } meter_out_t;

  // DUT connections; the driven inputs are known from time zero
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // increment, time_now
  logic [IN_TUSER_W-1:0]  s_tuser = '0;   // opcode
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // rate, average_rate, event_total
  logic [OUT_TUSER_W-1:0] m_tuser;        // recomputed

  event_rate_meter_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  job_t       job_q[$];
  meter_out_t rate_expect_q[$];

  int sent_cnt = 0;
  int cfg_cnt = 0;
  int result_cnt = 0;
  int recomp_cnt = 0;
  int err_cnt = 0;
  int quiet_cycles = 0;
  logic [TIME_W-1:0] gen_time = '0;
  logic calm;

  // stretch of the run with no idling on either side
  assign calm = (sent_cnt >= 500) && (sent_cnt < 700);

  // predictor state and register copies
  logic [CFG_W-1:0]  upd_interval;
  logic [CFG_W-1:0]  tick_rate;
  logic [CNT_W-1:0]  evt_total;
  logic [CNT_W-1:0]  cnt_mark;
  logic [TIME_W-1:0] time_mark;
  logic [RATE_W-1:0] cur_rate;
  logic [RATE_W-1:0] avg_rate;

  initial begin
    forever #5 clk = ~clk;
  end

  // floor(a * b * 256 / d), saturated to the rate width
  function automatic logic [RATE_W-1:0] scale_rate(input logic [31:0] a, input logic [31:0] b,
                                                  input logic [31:0] d);
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] rem;
    num = {32'd0, a} * {32'd0, b};
    quo = num / {32'd0, d};
    rem = num % {32'd0, d};
    if (quo > 64'h0000_0000_FFFF_FFFF) return RATE_MAX;
    return RATE_W'((quo << FRAC_W) + ((rem << FRAC_W) / {32'd0, d}));
  endfunction

  // advance the predicted meter by one transaction
  function automatic meter_out_t meter_step(input opcode_t op, input logic [INC_W-1:0] inc,
                                            input logic [TIME_W-1:0] now);
    meter_out_t res;
    logic [TIME_W-1:0] dt;
    logic [CNT_W-1:0]  dcnt;
    res.recomp = 1'b0;
    case (op)
      OP_COUNT: begin
        evt_total = evt_total + CNT_W'(inc);
        dt = now - time_mark;
        // past the update point only when time moved forward by more than the interval
        if (now >= time_mark && dt > upd_interval) begin
          dcnt = evt_total - cnt_mark;
          res.recomp = 1'b1;
          cur_rate = (dcnt == '0) ? '0 : scale_rate(dcnt, tick_rate, dt);
          avg_rate = scale_rate(evt_total, tick_rate, now);
          time_mark = now;
          cnt_mark = evt_total;
        end
      end
      OP_START:   cur_rate = RATE_ONE;
      OP_STOPPED: cur_rate = '0;
      default: begin
        evt_total = '0;
        cnt_mark = '0;
        time_mark = '0;
        cur_rate = '0;
        avg_rate = '0;
      end
    endcase
    res.rate = cur_rate;
    res.avg = avg_rate;
    res.total = evt_total;
    return res;
  endfunction

  // track register writes and accepted input transactions
  always @(posedge clk) begin
    if (rst) begin
      upd_interval = INTERVAL_RESET;
      tick_rate = TPS_RESET;
      evt_total = '0;
      cnt_mark = '0;
      time_mark = '0;
      cur_rate = '0;
      avg_rate = '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_UPDATE_INTERVAL) upd_interval = cfg_data;
        else if (cfg_index == REG_TICKS_PER_SECOND) tick_rate = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        rate_expect_q.push_back(meter_step(opcode_t'(s_tuser), s_tdata[INC_W-1:0],
                                           s_tdata[INC_W +: TIME_W]));
      end
    end
  end

  // feed items and register writes from the job queue
  always @(posedge clk) begin : drive
    job_t job;
    logic next_valid;
    logic next_we;
    next_valid = 1'b0;
    next_we = 1'b0;
    if (rst) begin
      s_tvalid <= 1'b0;
      cfg_we <= 1'b0;
    end else if (s_tvalid && !s_tready) begin
      // hold the transaction until it is taken
      cfg_we <= 1'b0;
    end else begin
      if (job_q.size() != 0) begin
        if (job_q[0].kind == JOB_ITEM) begin
          if (calm || $urandom_range(99) >= 12) begin
            job = job_q.pop_front();
            s_tdata <= {job.now, job.inc};
            s_tuser <= job.op;
            next_valid = 1'b1;
            sent_cnt <= sent_cnt + 1;
          end
        end else if (!s_tvalid && rate_expect_q.size() == 0) begin
          // block idle: every result is back
          job = job_q.pop_front();
          if (job.kind == JOB_CFG) begin
            cfg_index <= job.idx;
            cfg_data <= job.val;
            next_we = 1'b1;
            cfg_cnt <= cfg_cnt + 1;
          end
        end
      end
      s_tvalid <= next_valid;
      cfg_we <= next_we;
    end
  end

  // stall the result side at random
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= calm || ($urandom_range(99) >= 12);
  end

  task automatic flag_error(input string what);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) flag_error($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
  endtask

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : monitor
    meter_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      result_cnt++;
      if (m_tuser[0]) recomp_cnt++;
      if (rate_expect_q.size() == 0) begin
        flag_error("result with no item outstanding");
      end else begin
        want = rate_expect_q.pop_front();
        check_field("rate", want.rate, m_tdata[RATE_W-1:0]);
        check_field("average_rate", want.avg, m_tdata[RATE_W +: RATE_W]);
        check_field("event_total", want.total, m_tdata[2*RATE_W +: CNT_W]);
        check_field("recomputed", want.recomp, m_tuser[0]);
      end
    end
  end

  // stop a hung run
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_item(input opcode_t op, input logic [INC_W-1:0] inc,
                          input logic [TIME_W-1:0] now);
    job_t j;
    j = '0;
    j.kind = JOB_ITEM;
    j.op = op;
    j.inc = inc;
    j.now = now;
    job_q.push_back(j);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    job_t j;
    j = '0;
    j.kind = JOB_CFG;
    j.idx = idx;
    j.val = val;
    job_q.push_back(j);
  endtask

  task automatic add_drain();
    job_t j;
    j = '0;
    j.kind = JOB_DRAIN;
    job_q.push_back(j);
  endtask

  // one setting of the registers followed by random traffic with mostly advancing time
  task automatic run_phase(input int n, input logic [CFG_W-1:0] ivl, input logic [CFG_W-1:0] tps);
    int pick;
    logic [INC_W-1:0] inc;
    logic [TIME_W-1:0] step;
    opcode_t op;
    add_cfg(REG_UPDATE_INTERVAL, ivl);
    add_cfg(REG_TICKS_PER_SECOND, tps);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 15) inc = '0;
      else if (pick < 25) inc = '1;
      else if (pick < 60) inc = INC_W'($urandom_range(0, 255));
      else inc = INC_W'($urandom_range(0, 65535));

      pick = $urandom_range(99);
      if (pick < 40) step = $urandom_range(0, 64);
      else if (pick < 75) step = ivl + 1 + $urandom_range(0, 64);
      else if (pick < 88) step = ivl - $urandom_range(0, 1);
      else step = $urandom;

      pick = $urandom_range(99);
      if (pick < 80) begin
        op = OP_COUNT;
        gen_time = gen_time + step;
      end else if (pick < 86) begin
        op = OP_START;
      end else if (pick < 92) begin
        op = OP_STOPPED;
      end else if (pick < 96) begin
        op = OP_CLEAR;
      end else begin
        // noise: time jumps anywhere, often backwards
        op = OP_COUNT;
        gen_time = $urandom;
      end
      add_item(op, inc, (op == OP_COUNT) ? gen_time : TIME_W'($urandom));
      if (op == OP_CLEAR) gen_time = $urandom_range(0, 50);
      if ($urandom_range(99) == 0) add_drain();
    end
  endtask

  initial begin
    // directed: boundaries of the update point and every opcode
    add_item(OP_COUNT, 16'h0000, 32'd0);
    add_item(OP_COUNT, 16'hFFFF, 32'd1000);          // dt equals the interval: no update
    add_item(OP_COUNT, 16'h0005, 32'd1001);          // first update
    add_item(OP_COUNT, 16'h0000, 32'd2500);          // update with no new events
    add_item(OP_START, 16'hFFFF, 32'hFFFF_FFFF);     // increment ignored
    add_item(OP_COUNT, 16'h0003, 32'd2600);
    add_item(OP_STOPPED, 16'hABCD, 32'd123);
    add_item(OP_COUNT, 16'h0064, 32'd100);           // time going backwards
    add_item(OP_COUNT, 16'h0001, 32'hFFFF_FFFF);     // largest time value
    add_item(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    add_cfg(REG_UPDATE_INTERVAL, 32'd0);
    add_cfg(REG_TICKS_PER_SECOND, 32'hFFFF_FFFF);
    add_item(OP_COUNT, 16'hFFFF, 32'd1);             // both rates saturate
    add_item(OP_COUNT, 16'h0000, 32'd1);             // zero time difference
    add_item(OP_COUNT, 16'h0000, 32'd2);             // no new events
    add_item(OP_START, 16'h0000, 32'd0);
    add_cfg(REG_TICKS_PER_SECOND, 32'd0);
    add_item(OP_COUNT, 16'h0007, 32'd3);             // zero tick rate gives zero rates
    add_item(OP_CLEAR, 16'h0000, 32'd0);
    add_cfg(REG_UPDATE_INTERVAL, 32'hFFFF_FFFE);
    add_cfg(REG_TICKS_PER_SECOND, 32'd1);
    add_item(OP_COUNT, 16'h8000, 32'hFFFF_FFFE);     // just short of the update point
    add_item(OP_COUNT, 16'h7FFF, 32'hFFFF_FFFF);     // just past it
    add_item(OP_CLEAR, 16'h5555, 32'h5555_5555);
    add_cfg(REG_UPDATE_INTERVAL, 32'hFFFF_FFFF);
    add_item(OP_COUNT, 16'hAAAA, 32'hFFFF_FFFF);     // can never pass the largest interval
    add_drain();

    // random traffic over several register settings
    run_phase(150, 32'd1000, 32'd1000);
    run_phase(150, 32'd0, 32'd1);
    run_phase(150, 32'd16, 32'hFFFF_FFFF);
    run_phase(150, $urandom, $urandom_range(1, 32'hFFFF_FFFF));
    run_phase(150, $urandom_range(0, 5000), $urandom_range(1, 1000000));
    run_phase(40, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(150, 32'd200, 32'hFFFF_FFFF);
    run_phase(60, 32'd5, 32'd0);
    run_phase(150, 32'd1, 32'd50000);
    run_phase(150, $urandom_range(0, 300), $urandom);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (job_q.size() != 0 || s_tvalid || rate_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (rate_expect_q.size() != 0) $display("%0d results never arrived", rate_expect_q.size());
    $display("Sent %0d items across %0d register writes; checked %0d results, %0d with rate updates.",
             sent_cnt, cfg_cnt, result_cnt, recomp_cnt);
    $display("Field mismatches: %0d", err_cnt);
    if (err_cnt == 0 && rate_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/erm_pkg.sv
rtl/erm_divider.sv
rtl/event_rate_meter_unit.sv
rtl/erm_checker.sv
tb/tb_event_rate_meter_unit.sv
